// ----- rtl/lcd_text_glyph_emitter_macros.svh -----
// -----------------------------------------------------------------------------
// LCD text glyph emitter assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef LCD_TEXT_GLYPH_EMITTER_MACROS_SVH
`define LCD_TEXT_GLYPH_EMITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTGE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTGE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- rtl/ltge_pkg.sv -----
// -----------------------------------------------------------------------------
// LCD text glyph emitter package
// Transaction types, LCD command constants and the sequencer microcode table.
// -----------------------------------------------------------------------------
package ltge_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic [6:0] FIRST_CHAR  = 7'd32;
    localparam int         WRAP_LIMIT  = 127;
    localparam logic [7:0] PAGE_CMD    = 8'hB0;
    localparam logic [7:0] COL_HI_CMD  = 8'h10;
    localparam logic [7:0] COL_LO_MASK = 8'h0F;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] font_address;
        logic [7:0] font_byte;
        logic [2:0] start_page;
        logic [6:0] start_column;
        logic [6:0] character;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } out_t;

    typedef enum logic [5:0] {
        STEP_IDLE  = 6'b000001,
        STEP_WRAP  = 6'b000010,
        STEP_PAGE  = 6'b000100,
        STEP_COLHI = 6'b001000,
        STEP_COLLO = 6'b010000,
        STEP_DATA  = 6'b100000
    } step_t;

    typedef enum logic [1:0] {
        SEL_PAGE  = 2'd0,
        SEL_COLHI = 2'd1,
        SEL_COLLO = 2'd2,
        SEL_DATA  = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        JMP_ALWAYS = 2'd0,
        JMP_DRAW   = 2'd1,
        JMP_LAST   = 2'd2
    } jump_t;

    typedef struct packed {
        logic  emit;
        sel_t  sel;
        logic  wrap;
        logic  rd_base;
        logic  rd_ptr;
        jump_t jump;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic draw_go;
        logic out_free;
        logic data_last;
    } status_t;

    function automatic ctl_t microcode(step_t step);
        ctl_t w;
        unique case (step)
            STEP_IDLE:  w = '{1'b0, SEL_PAGE,  1'b0, 1'b0, 1'b0, JMP_DRAW,   STEP_WRAP};
            STEP_WRAP:  w = '{1'b0, SEL_PAGE,  1'b1, 1'b0, 1'b0, JMP_ALWAYS, STEP_PAGE};
            STEP_PAGE:  w = '{1'b1, SEL_PAGE,  1'b0, 1'b0, 1'b0, JMP_ALWAYS, STEP_COLHI};
            STEP_COLHI: w = '{1'b1, SEL_COLHI, 1'b0, 1'b0, 1'b0, JMP_ALWAYS, STEP_COLLO};
            STEP_COLLO: w = '{1'b1, SEL_COLLO, 1'b0, 1'b1, 1'b0, JMP_ALWAYS, STEP_DATA};
            STEP_DATA:  w = '{1'b1, SEL_DATA,  1'b0, 1'b0, 1'b1, JMP_LAST,   STEP_IDLE};
            default:    w = '{1'b0, SEL_PAGE,  1'b0, 1'b0, 1'b0, JMP_ALWAYS, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/lcd_text_glyph_emitter.sv -----
// Font-load and start transactions are taken in the idle step, which they do not leave.
// A draw transaction runs the accept step, a cursor wrap step, three command bytes (page, column high,
// column low), then one byte per glyph column, paced by the single read port of the font store;
// the first byte is registered into the output register in the page step.
// Output back-pressure stalls the microcode step in place.
// Reset clears the cursor to page 0, column 0 and the sequencer to idle; the font is not cleared.
// -----------------------------------------------------------------------------
// LCD text glyph emitter
// Turns characters into command and display data bytes for a page-organised LCD.
// -----------------------------------------------------------------------------
module lcd_text_glyph_emitter
    import ltge_pkg::*;
#(
    parameter int GLYPH_COUNT = 96,
    parameter int GLYPH_WIDTH = 7
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    ctl_t    ctl;
    status_t status;
    logic    accept;

    assign in_ready = (ctl.jump == JMP_DRAW);
    assign accept   = in_valid && in_ready;

    ltge_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    ltge_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .accept    (accept),
        .in_item   (in_item),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ----- rtl/ltge_sequencer.sv -----
// -----------------------------------------------------------------------------
// LCD text glyph emitter sequencer
// Step register, microcode lookup and conditional jump logic.
// -----------------------------------------------------------------------------
module ltge_sequencer
    import ltge_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctl_t    ctl
);

    step_t step_reg;
    step_t step_next;
    logic  advance;

    assign ctl     = microcode(step_reg);
    assign advance = !ctl.emit || status.out_free;

    always_comb
    begin
        step_next = step_reg;
        unique case (ctl.jump)
            JMP_ALWAYS:
            begin
                if (advance)
                begin
                    step_next = ctl.target;
                end
            end
            JMP_DRAW:
            begin
                if (status.draw_go)
                begin
                    step_next = ctl.target;
                end
            end
            JMP_LAST:
            begin
                if (advance && status.data_last)
                begin
                    step_next = ctl.target;
                end
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/ltge_datapath.sv -----
// -----------------------------------------------------------------------------
// LCD text glyph emitter datapath
// Font store, page and column cursor, glyph pointer and output register.
// -----------------------------------------------------------------------------
module ltge_datapath
    import ltge_pkg::*;
#(
    parameter int GLYPH_COUNT = 96,
    parameter int GLYPH_WIDTH = 7
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctl_t    ctl,
    input  logic    accept,
    input  in_t     in_item,
    output status_t status,
    output logic    out_valid,
    input  logic    out_ready,
    output out_t    out_item
);

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
    localparam int AW = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    localparam int CW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

    logic [7:0]    font_mem [FONT_DEPTH];

    logic [2:0]    page_reg;
    logic [6:0]    col_reg;
    logic [6:0]    char_reg;
    logic          blank_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg;
    out_t          out_reg;

    logic          out_free;
    logic          advance;
    logic          data_last;
    logic          draw_go;
    logic [6:0]    glyph_idx;
    logic          glyph_blank;
    logic          wrap_hit;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [7:0]    emit_byte;

    assign out_free    = !out_valid_reg || out_ready;
    assign advance     = !ctl.emit || out_free;
    assign data_last   = (cnt_reg == CW'(GLYPH_WIDTH - 1));
    assign draw_go     = accept && (in_item.operation == OP_DRAW);
    assign glyph_idx   = char_reg - FIRST_CHAR;
    assign glyph_blank = (char_reg < FIRST_CHAR) || (32'(glyph_idx) >= GLYPH_COUNT);
    assign wrap_hit    = (32'(col_reg) + GLYPH_WIDTH) >= WRAP_LIMIT;
    assign rd_en       = advance && (ctl.rd_base || (ctl.rd_ptr && !data_last));
    assign rd_addr     = ctl.rd_base ? base_reg : ptr_reg;
    assign wr_addr     = AW'(in_item.font_address);
    assign wr_en       = accept && (in_item.operation == OP_LOAD)
                         && (32'(in_item.font_address) < FONT_DEPTH);

    assign status.draw_go   = draw_go;
    assign status.out_free  = out_free;
    assign status.data_last = data_last;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        unique case (ctl.sel)
            SEL_PAGE:  emit_byte = PAGE_CMD | {5'd0, page_reg};
            SEL_COLHI: emit_byte = COL_HI_CMD | {5'd0, col_reg[6:4]};
            SEL_COLLO: emit_byte = {1'b0, col_reg} & COL_LO_MASK;
            SEL_DATA:  emit_byte = blank_reg ? 8'h00 : rd_data_reg;
            default:   emit_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            font_mem[wr_addr] <= in_item.font_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= 3'd0;
            col_reg  <= 7'd0;
        end
        else if (accept && (in_item.operation == OP_START))
        begin
            page_reg <= in_item.start_page;
            col_reg  <= in_item.start_column;
        end
        else if (ctl.wrap && wrap_hit)
        begin
            page_reg <= page_reg + 3'd1;
            col_reg  <= 7'd0;
        end
        else if (ctl.emit && advance && (ctl.sel == SEL_DATA) && data_last)
        begin
            col_reg <= col_reg + 7'(GLYPH_WIDTH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw_go)
        begin
            char_reg <= in_item.character;
        end
        if (ctl.wrap)
        begin
            blank_reg <= glyph_blank;
            base_reg  <= glyph_blank ? '0 : AW'(32'(glyph_idx) * GLYPH_WIDTH);
        end
        if (ctl.rd_base && advance)
        begin
            ptr_reg <= base_reg + AW'(1);
            cnt_reg <= '0;
        end
        else if (ctl.rd_ptr && advance && !data_last)
        begin
            ptr_reg <= ptr_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit && advance)
        begin
            out_reg.out_byte <= emit_byte;
            out_reg.is_data  <= (ctl.sel == SEL_DATA);
            out_reg.last     <= (ctl.sel == SEL_DATA) && data_last;
        end
    end

endmodule

// ----- rtl/ltge_checker.sv -----
// -----------------------------------------------------------------------------
// LCD text glyph emitter checker
// Port-level assertions on the output stream, bound to the top level.
// -----------------------------------------------------------------------------
`include "lcd_text_glyph_emitter_macros.svh"

module ltge_checker
    import ltge_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_item
);

    `LTGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    `LTGE_ASSERT_NOW(a_last_is_data, out_valid && out_item.last, out_item.is_data)

    // A character's bytes must all be produced before another transaction is taken.
    `LTGE_ASSERT_NOW(a_busy_until_last, out_valid && !out_item.last, !in_ready)

    `LTGE_ASSERT_NOW(a_command_code, out_valid && !out_item.is_data, out_item.out_byte[7:4] == 4'hB || out_item.out_byte[7:4] == 4'h1 || out_item.out_byte[7:4] == 4'h0)

endmodule

bind lcd_text_glyph_emitter ltge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
